/* hw/rtl/ycbcr420_pair_to_rgb565_assert.svh */
// Assertion macros for the YCbCr pair to RGB565 converter.
// Used by the top level; expects clk_i and rst_ni in the enclosing scope.
`ifndef YCBCR420_PAIR_TO_RGB565_ASSERT_SVH
`define YCBCR420_PAIR_TO_RGB565_ASSERT_SVH

// Checked only while out of reset.
`define Y2R_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, reset included.
`define Y2R_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* hw/rtl/y2r_pkg.sv */
// Shared constants, types and arithmetic helpers of the YCbCr to RGB565 converter.
// No dependencies.
`timescale 1ns / 1ps

package y2r_pkg;

  // Channel widths of the packed pixel.
  localparam int unsigned RED_BITS   = 5;
  localparam int unsigned GREEN_BITS = 6;
  localparam int unsigned BLUE_BITS  = 5;
  localparam int unsigned PACK_W     = RED_BITS + GREEN_BITS + BLUE_BITS;
  localparam int unsigned PIXEL_W    = 16;

  // Conversion weights, luma scaled by 128.
  localparam int LUMA_WEIGHT = 128;
  localparam int CR_TO_RED   = 179;
  localparam int CB_TO_GREEN = -43;
  localparam int CR_TO_GREEN = -91;
  localparam int CB_TO_BLUE  = 227;
  localparam int ROUND_BIAS  = 127 * LUMA_WEIGHT;
  localparam int SCALE_SHIFT = 15;

  // Weighted sums lie in -29056..61469; scaled sums stay below 2^24 in magnitude.
  localparam int unsigned SUM_W = 18;
  localparam int unsigned SCL_W = 26;
  localparam int unsigned CLP_W = SCL_W - SCALE_SHIFT;

  typedef logic signed [SUM_W-1:0] sum_t;
  typedef logic signed [SCL_W-1:0] scaled_t;

  // Centered chroma pair, each in -128..127.
  typedef struct packed {
    logic signed [7:0] cb;
    logic signed [7:0] cr;
  } chroma_t;

  // (2^bits-1)*v + floor(v / 2^(8-bits)) + bias, before the final shift.
  function automatic scaled_t scale_sum(input sum_t v, input int unsigned bits);
    int top;
    top = (1 << bits) - 1;
    return SCL_W'(top * v + (v >>> (8 - bits)) + ROUND_BIAS);
  endfunction

  // Final floor shift and clamp to 0..2^bits-1.
  function automatic logic [7:0] shift_clamp(input scaled_t s, input int unsigned bits);
    logic signed [CLP_W-1:0] q;
    logic signed [CLP_W-1:0] top;
    logic [7:0]              res;
    q   = CLP_W'(s >>> SCALE_SHIFT);
    top = CLP_W'((1 << bits) - 1);
    if (q < 0) begin
      res = '0;
    end else if (q > top) begin
      res = top[7:0];
    end else begin
      res = q[7:0];
    end
    return res;
  endfunction

endpackage

/* hw/rtl/y2r_pixel_pipe.sv */
// Three-stage datapath for one pixel: weighted sums, scaling, clamp and pack.
// Depends on y2r_pkg.
`timescale 1ns / 1ps

module y2r_pixel_pipe (
  input  logic                         clk_i,
  input  logic [7:0]                   luma_i,
  input  y2r_pkg::chroma_t             chroma_i,
  output logic [y2r_pkg::PIXEL_W-1:0]  pixel_o
);

  y2r_pkg::sum_t    yy;
  y2r_pkg::sum_t    cb_ext;
  y2r_pkg::sum_t    cr_ext;
  y2r_pkg::sum_t    sum_r_d, sum_g_d, sum_b_d;
  y2r_pkg::sum_t    sum_r_q, sum_g_q, sum_b_q;
  y2r_pkg::scaled_t scl_r_d, scl_g_d, scl_b_d;
  y2r_pkg::scaled_t scl_r_q, scl_g_q, scl_b_q;
  logic [7:0]       red, green, blue;
  logic [y2r_pkg::PACK_W+y2r_pkg::PIXEL_W-1:0] word;
  logic [y2r_pkg::PIXEL_W-1:0] pixel_d, pixel_q;

  always_comb begin
    yy     = y2r_pkg::SUM_W'(y2r_pkg::LUMA_WEIGHT * $signed({1'b0, luma_i}));
    cb_ext = y2r_pkg::SUM_W'(chroma_i.cb);
    cr_ext = y2r_pkg::SUM_W'(chroma_i.cr);
    sum_r_d = y2r_pkg::SUM_W'(yy + y2r_pkg::CR_TO_RED * cr_ext);
    sum_g_d = y2r_pkg::SUM_W'(yy + y2r_pkg::CB_TO_GREEN * cb_ext
                                 + y2r_pkg::CR_TO_GREEN * cr_ext);
    sum_b_d = y2r_pkg::SUM_W'(yy + y2r_pkg::CB_TO_BLUE * cb_ext);
  end

  always_comb begin
    scl_r_d = y2r_pkg::scale_sum(sum_r_q, y2r_pkg::RED_BITS);
    scl_g_d = y2r_pkg::scale_sum(sum_g_q, y2r_pkg::GREEN_BITS);
    scl_b_d = y2r_pkg::scale_sum(sum_b_q, y2r_pkg::BLUE_BITS);
  end

  always_comb begin
    red   = y2r_pkg::shift_clamp(scl_r_q, y2r_pkg::RED_BITS);
    green = y2r_pkg::shift_clamp(scl_g_q, y2r_pkg::GREEN_BITS);
    blue  = y2r_pkg::shift_clamp(scl_b_q, y2r_pkg::BLUE_BITS);
    // Wider channel settings push red past bit 15; only the low 16 bits are kept.
    word    = {{y2r_pkg::PIXEL_W{1'b0}}, red[y2r_pkg::RED_BITS-1:0],
               green[y2r_pkg::GREEN_BITS-1:0], blue[y2r_pkg::BLUE_BITS-1:0]};
    pixel_d = word[y2r_pkg::PIXEL_W-1:0];
  end

  // Payload registers only; the valid bits live in the top level.
  always_ff @(posedge clk_i) begin
    sum_r_q <= sum_r_d;
    sum_g_q <= sum_g_d;
    sum_b_q <= sum_b_d;
    scl_r_q <= scl_r_d;
    scl_g_q <= scl_g_d;
    scl_b_q <= scl_b_d;
    pixel_q <= pixel_d;
  end

  assign pixel_o = pixel_q;

endmodule

/* hw/rtl/ycbcr420_pair_to_rgb565.sv */
// Top level of the full-range YCbCr pixel pair to RGB565 converter.
// Depends on y2r_pkg, y2r_pixel_pipe and ycbcr420_pair_to_rgb565_assert.svh.
`timescale 1ns / 1ps

// Converts two neighboring luma bytes and their shared Cb/Cr bytes into two
// RGB565 pixels.
// A beat is taken at each rising edge with start_i high and busy_o low. busy_o
// is tied low, so a new beat may be issued in every cycle.
// A beat taken at an edge passes the input, weighted sum, scaling and pixel
// registers in that order, then shows up on pixel_first_o and pixel_second_o,
// with done_o high, for a single cycle, and is taken by the receiver at its end.
// Throughput is one pixel pair per cycle, set by the four register stages
// (input and chroma centering, weighted sums, scaling, clamp and pack) that
// every beat passes through in lockstep.
// The results are shown for exactly one cycle and the receiver cannot hold
// them off; it must take each beat when done_o is high.
// Reset clears the valid bits of all stages, so no result appears from beats
// that were in flight; the payload registers are not reset.
module ycbcr420_pair_to_rgb565 (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [7:0]  luma_first_i,
  input  logic [7:0]  luma_second_i,
  input  logic [7:0]  chroma_blue_i,
  input  logic [7:0]  chroma_red_i,
  output logic        done_o,
  output logic [15:0] pixel_first_o,
  output logic [15:0] pixel_second_o
);

  localparam int unsigned STAGES = 4;

  logic [STAGES-1:0] valid_d, valid_q;
  logic [7:0]        luma_first_q, luma_second_q;
  y2r_pkg::chroma_t  chroma_d, chroma_q;
  logic              accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // Flipping the top bit of an offset byte gives the byte minus 128 as signed.
  always_comb begin
    chroma_d.cb = $signed({~chroma_blue_i[7], chroma_blue_i[6:0]});
    chroma_d.cr = $signed({~chroma_red_i[7], chroma_red_i[6:0]});
    valid_d     = {valid_q[STAGES-2:0], accept};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    luma_first_q  <= luma_first_i;
    luma_second_q <= luma_second_i;
    chroma_q      <= chroma_d;
  end

  y2r_pixel_pipe u_pixel_first (
    .clk_i    (clk_i),
    .luma_i   (luma_first_q),
    .chroma_i (chroma_q),
    .pixel_o  (pixel_first_o)
  );

  y2r_pixel_pipe u_pixel_second (
    .clk_i    (clk_i),
    .luma_i   (luma_second_q),
    .chroma_i (chroma_q),
    .pixel_o  (pixel_second_o)
  );

  assign done_o = valid_q[STAGES-1];

`include "ycbcr420_pair_to_rgb565_assert.svh"

  `Y2R_ASSERT(a_beat_gives_result, accept |-> ##4 done_o, "accepted beat produced no result")
  `Y2R_ASSERT(a_result_has_beat, done_o |-> $past(accept, 4), "result without an accepted beat")
  `Y2R_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !done_o, "result strobe during reset")

endmodule

/* verif/ycbcr420_pair_to_rgb565_tb.sv */
// Self-checking testbench for the YCbCr pixel pair to RGB565 converter.
// Drives ycbcr420_pair_to_rgb565 alone and predicts every packed pixel pair in place.
`timescale 1ns / 1ps

module ycbcr420_pair_to_rgb565_tb;

  localparam int RED_W         = 5;
  localparam int GREEN_W       = 6;
  localparam int BLUE_W        = 5;
  localparam int Y_WEIGHT      = 128;
  localparam int CR_RED        = 179;
  localparam int CB_GREEN      = -43;
  localparam int CR_GREEN      = -91;
  localparam int CB_BLUE       = 227;
  localparam int ROUNDING      = 127 * 128;
  localparam int FINAL_SHIFT   = 15;
  localparam int CHROMA_CENTER = 128;
  localparam int MAX_GAP       = 11;
  localparam int IDLE_LIMIT    = 200;
  localparam int DRAIN_CYCLES  = 8;

  logic        clk_i  = 1'b0;
  logic        rst_ni;
  logic        start_i = 1'b0;
  logic        busy_o;
  logic [7:0]  luma_first_i  = '0;
  logic [7:0]  luma_second_i = '0;
  logic [7:0]  chroma_blue_i = '0;
  logic [7:0]  chroma_red_i  = '0;
  logic        done_o;
  logic [15:0] pixel_first_o;
  logic [15:0] pixel_second_o;

  typedef struct {
    logic [15:0] first;
    logic [15:0] second;
    logic [7:0]  y0;
    logic [7:0]  y1;
    logic [7:0]  cb;
    logic [7:0]  cr;
  } pixel_pair_t;

  pixel_pair_t pending_pixels[$];
  int          errors        = 0;
  int          pairs_sent    = 0;
  int          pairs_checked = 0;

  ycbcr420_pair_to_rgb565 u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .luma_first_i  (luma_first_i),
    .luma_second_i (luma_second_i),
    .chroma_blue_i (chroma_blue_i),
    .chroma_red_i  (chroma_red_i),
    .done_o        (done_o),
    .pixel_first_o (pixel_first_o),
    .pixel_second_o(pixel_second_o)
  );

  always #1 clk_i = ~clk_i;

  // Scales one weighted sum to a channel of the given width and clamps it.
  function automatic logic [7:0] scale_channel(input int sum, input int bits);
    int top;
    int q;
    top = (1 << bits) - 1;
    q = (top * sum + (sum >>> (8 - bits)) + ROUNDING) >>> FINAL_SHIFT;
    if (q < 0) begin
      q = 0;
    end else if (q > top) begin
      q = top;
    end
    return 8'(q);
  endfunction

  function automatic logic [15:0] rgb565_of(input logic [7:0] y, input int cb, input int cr);
    int          yy;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [31:0] word;
    yy = Y_WEIGHT * int'(y);
    r = scale_channel(yy + CR_RED * cr, RED_W);
    g = scale_channel(yy + CB_GREEN * cb + CR_GREEN * cr, GREEN_W);
    b = scale_channel(yy + CB_BLUE * cb, BLUE_W);
    word = (32'(r) << (GREEN_W + BLUE_W)) | (32'(g) << BLUE_W) | 32'(b);
    return word[15:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] exp_v,
                                 input logic [15:0] got_v);
    $display("MISMATCH at %0t: %s expected %h got %h", $realtime, what, exp_v, got_v);
    errors++;
  endtask

  // Sends one beat after the given number of idle cycles; start stays high when
  // the gap is zero so back-to-back beats go out in consecutive cycles.
  task automatic drive_pair(input logic [7:0] y0, input logic [7:0] y1,
                            input logic [7:0] cb, input logic [7:0] cr, input int gap);
    pixel_pair_t expected;
    int          cb_c;
    int          cr_c;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i       <= 1'b1;
    luma_first_i  <= y0;
    luma_second_i <= y1;
    chroma_blue_i <= cb;
    chroma_red_i  <= cr;
    cb_c = int'(cb) - CHROMA_CENTER;
    cr_c = int'(cr) - CHROMA_CENTER;
    expected.first  = rgb565_of(y0, cb_c, cr_c);
    expected.second = rgb565_of(y1, cb_c, cr_c);
    expected.y0 = y0;
    expected.y1 = y1;
    expected.cb = cb;
    expected.cr = cr;
    do @(posedge clk_i); while (busy_o);
    pending_pixels.push_back(expected);
    pairs_sent++;
  endtask

  always @(posedge clk_i) begin : check_results
    pixel_pair_t exp_pair;
    string       tag;
    if (rst_ni && done_o) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("result beat with no pair pending, pixel_first", 16'h0,
                        pixel_first_o);
      end else begin
        exp_pair = pending_pixels.pop_front();
        tag = $sformatf("Y %h/%h Cb %h Cr %h", exp_pair.y0, exp_pair.y1, exp_pair.cb,
                        exp_pair.cr);
        if (pixel_first_o !== exp_pair.first) begin
          report_mismatch({tag, " pixel_first"}, exp_pair.first, pixel_first_o);
        end
        if (pixel_second_o !== exp_pair.second) begin
          report_mismatch({tag, " pixel_second"}, exp_pair.second, pixel_second_o);
        end
        pairs_checked++;
      end
    end
  end

  // Luma and chroma at their rails, which drive every channel into both clamps.
  task automatic test_extremes();
    logic [7:0] rails[3];
    rails = '{8'd0, 8'd128, 8'd255};
    foreach (rails[i]) begin
      foreach (rails[j]) begin
        drive_pair(8'd0, 8'd255, rails[i], rails[j], $urandom_range(0, MAX_GAP));
        drive_pair(8'd255, 8'd0, rails[i], rails[j], $urandom_range(0, MAX_GAP));
      end
    end
    drive_pair(8'd0, 8'd0, 8'd128, 8'd128, 0);
    drive_pair(8'd255, 8'd255, 8'd128, 8'd128, 0);
  endtask

  // Chroma near the center and the rails, with random luma.
  task automatic test_chroma_rails();
    logic [7:0] picks[7];
    picks = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
    for (int n = 0; n < 50; n++) begin
      drive_pair(8'($urandom), 8'($urandom), picks[$urandom_range(0, 6)],
                 picks[$urandom_range(0, 6)], $urandom_range(0, MAX_GAP));
    end
  endtask

  // Uniform random pairs; each block of 25 beats has no gaps with a chance of one in four, else random gaps.
  task automatic test_random_stream();
    bit burst;
    int gap;
    burst = 1'b0;
    for (int n = 0; n < 700; n++) begin
      if (n % 25 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      gap = burst ? 0 : $urandom_range(0, MAX_GAP);
      drive_pair(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), gap);
    end
  endtask

  task automatic test_back_to_back();
    for (int n = 0; n < 100; n++) begin
      drive_pair(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 0);
    end
  endtask

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (start_i && !busy_o) || done_o) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Timeout: no beat moved for %0d cycles, %0d pairs pending", IDLE_LIMIT,
             pending_pixels.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    // Driven at time zero so the falling reset edge reaches the design.
    rst_ni <= 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_extremes();
    test_chroma_rails();
    test_random_stream();
    test_back_to_back();
    start_i <= 1'b0;
    while (pending_pixels.size() > 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Sent %0d pixel pairs, checked %0d: rail values, chroma near center and rails,",
             pairs_sent, pairs_checked);
    $display("and random pairs with random gaps and back-to-back bursts; %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
